// ===== design/rsmt_pkg.sv =====
// ----------------------------------------------------------------------------
// rsmt_pkg
// Shared types, constants and helpers for the running smallest-m tracker.
// ----------------------------------------------------------------------------
package rsmt_pkg;

  // store geometry
  localparam int MAX_KEEP   = 32;
  localparam int VALUE_BITS = 18;
  localparam int IDX_W      = (MAX_KEEP > 1) ? $clog2(MAX_KEEP) : 1;
  localparam int CNT_W      = $clog2(MAX_KEEP + 1);

  // fixed field widths
  localparam int LIMIT_W = 6;
  localparam int COUNT_W = 6;

  // command codes
  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_DRAIN  = 1'b1;

  typedef logic [VALUE_BITS-1:0] value_t;
  typedef logic [CNT_W-1:0]      count_t;
  typedef logic [IDX_W-1:0]      idx_t;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RESULT,
    ST_DRAIN
  } ctrl_state_t;

  // controller to datapath commands
  typedef struct packed {
    logic insert_en;
    logic drain_start;
    logic drain_adv;
    logic drain_clear;
    logic drain_mode;
  } dp_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic drain_last;
  } dp_sts_t;

  // one result item
  typedef struct packed {
    value_t               threshold;
    logic                 full_res;
    value_t               kept_value;
    logic [COUNT_W-1:0]   kept_count;
    logic                 empty_res;
    logic                 last;
  } result_t;

  // effective limit: zero acts as one, large values saturate at the store size
  function automatic count_t eff_limit(input logic [LIMIT_W-1:0] lim);
    count_t res;
    if (lim == '0) begin
      res = count_t'(1);
    end else if (int'(lim) > MAX_KEEP) begin
      res = count_t'(MAX_KEEP);
    end else begin
      res = count_t'(lim);
    end
    return res;
  endfunction

endpackage

// ===== design/rsmt_in_if.sv =====
// ----------------------------------------------------------------------------
// rsmt_in_if
// Input channel: command and value with valid/ready.
// ----------------------------------------------------------------------------
interface rsmt_in_if
  import rsmt_pkg::*;
();
  logic   valid;
  logic   ready;
  logic   cmd;
  value_t value;

  modport source (output valid, output cmd, output value, input ready);
  modport sink   (input valid, input cmd, input value, output ready);
endinterface

// ===== design/rsmt_out_if.sv =====
// ----------------------------------------------------------------------------
// rsmt_out_if
// Result channel: one result item per transfer with valid/ready.
// ----------------------------------------------------------------------------
interface rsmt_out_if
  import rsmt_pkg::*;
();
  logic               valid;
  logic               ready;
  value_t             threshold;
  logic               full_res;
  value_t             kept_value;
  logic [COUNT_W-1:0] kept_count;
  logic               empty_res;
  logic               last;

  modport source (output valid, output threshold, output full_res, output kept_value,
                  output kept_count, output empty_res, output last, input ready);
  modport sink   (input valid, input threshold, input full_res, input kept_value,
                  input kept_count, input empty_res, input last, output ready);
endinterface

// ===== design/rsmt_cfg_if.sv =====
// ----------------------------------------------------------------------------
// rsmt_cfg_if
// Configuration write channel for the keep limit register.
// ----------------------------------------------------------------------------
interface rsmt_cfg_if
  import rsmt_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [LIMIT_W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== design/rsmt_ctrl.sv =====
// ----------------------------------------------------------------------------
// rsmt_ctrl
// Controller: sequences accept, insert result and drain emission.
// ----------------------------------------------------------------------------
module rsmt_ctrl
  import rsmt_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  input  logic    in_cmd,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  output dp_cmd_t dp_cmd,
  input  dp_sts_t dp_sts
);

  ctrl_state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    dp_cmd    = '0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_cmd == CMD_INSERT) begin
            dp_cmd.insert_en = 1'b1;
            state_nxt        = ST_RESULT;
          end else begin
            dp_cmd.drain_start = 1'b1;
            state_nxt          = ST_DRAIN;
          end
        end
      end
      ST_RESULT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_DRAIN: begin
        out_valid         = 1'b1;
        dp_cmd.drain_mode = 1'b1;
        if (out_ready) begin
          if (dp_sts.drain_last) begin
            dp_cmd.drain_clear = 1'b1;
            state_nxt          = ST_IDLE;
          end else begin
            dp_cmd.drain_adv = 1'b1;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== design/rsmt_dpath.sv =====
// ----------------------------------------------------------------------------
// rsmt_dpath
// Datapath: sorted register row with parallel compare-and-shift insert,
// limit register, drain pointer and result formatting.
// ----------------------------------------------------------------------------
module rsmt_dpath
  import rsmt_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  dp_cmd_t            dp_cmd,
  output dp_sts_t            dp_sts,
  input  value_t             in_value,
  input  logic               cfg_we,
  input  logic [LIMIT_W-1:0] cfg_data,
  output result_t            res
);

  value_t             kept_r [MAX_KEEP];
  value_t             kept_nxt [MAX_KEEP];
  count_t             count_r;
  count_t             count_nxt;
  count_t             before_r;
  idx_t               idx_r;
  logic [LIMIT_W-1:0] limit_r;

  count_t                lim;
  logic                  not_full;
  logic [MAX_KEEP-1:0]   gt;
  logic                  grow;
  count_t                cfg_lim;
  idx_t                  top_idx;

  // compare every kept entry against the new value, then shift the tail up
  always_comb begin
    lim      = eff_limit(limit_r);
    not_full = (count_r < lim);
    for (int i = 0; i < MAX_KEEP; i++) begin
      gt[i] = (count_t'(i) < count_r) && (kept_r[i] > in_value);
    end
    grow = not_full || (|gt);
    kept_nxt[0] = (gt[0] || count_r == '0) ? in_value : kept_r[0];
    for (int i = 1; i < MAX_KEEP; i++) begin
      if (gt[i-1]) begin
        kept_nxt[i] = kept_r[i-1];
      end else if (gt[i] || count_t'(i) == count_r) begin
        kept_nxt[i] = in_value;
      end else begin
        kept_nxt[i] = kept_r[i];
      end
    end
  end

  // kept count: grows on insert, clamps on limit write, clears after drain
  assign cfg_lim = eff_limit(cfg_data);

  always_comb begin
    count_nxt = count_r;
    if (dp_cmd.insert_en && not_full) begin
      count_nxt = count_r + count_t'(1);
    end else if (dp_cmd.drain_clear) begin
      count_nxt = '0;
    end else if (cfg_we && count_r > cfg_lim) begin
      count_nxt = cfg_lim;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      limit_r <= LIMIT_W'(1);
      idx_r   <= '0;
    end else begin
      count_r <= count_nxt;
      if (cfg_we) begin
        limit_r <= cfg_data;
      end
      if (dp_cmd.drain_start) begin
        idx_r <= '0;
      end else if (dp_cmd.drain_adv) begin
        idx_r <= idx_r + idx_t'(1);
      end
    end
  end

  // kept values and count before the current item
  always_ff @(posedge clk) begin
    if (dp_cmd.insert_en && grow) begin
      kept_r <= kept_nxt;
    end
    if (dp_cmd.insert_en || dp_cmd.drain_start) begin
      before_r <= count_r;
    end
  end

  // drain ends on the last kept entry, or at once when nothing is kept
  assign dp_sts.drain_last = (before_r == '0) || (count_t'(idx_r) + count_t'(1) == before_r);

  // result formatting
  assign top_idx = idx_t'(count_r - count_t'(1));

  always_comb begin
    res            = '0;
    res.kept_count = COUNT_W'(before_r);
    res.last       = 1'b1;
    if (dp_cmd.drain_mode) begin
      res.last = dp_sts.drain_last;
      if (before_r == '0) begin
        res.empty_res = 1'b1;
      end else begin
        res.kept_value = kept_r[idx_r];
      end
    end else if (count_r >= lim && count_r != '0) begin
      res.full_res  = 1'b1;
      res.threshold = kept_r[top_idx];
    end
  end

endmodule

// ===== design/running_smallest_m_tracker.sv =====
// ----------------------------------------------------------------------------
// running_smallest_m_tracker
// Keeps the smallest keep_limit values inserted since the last drain and
// drains them in ascending order.
// ----------------------------------------------------------------------------
// latency: an insert result is offered the cycle after the input transfer
// throughput: one item at a time; a new command is taken only once every result of
//   the last one is accepted; a drain gives one value per cycle from the row while out_ready is high
// reset: kept count cleared, keep_limit set to 1, no clearing pass needed
module running_smallest_m_tracker
  import rsmt_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  rsmt_in_if.sink       in_ch,
  rsmt_out_if.source    out_ch,
  rsmt_cfg_if.sink      cfg_ch
);

  dp_cmd_t dp_cmd;
  dp_sts_t dp_sts;
  result_t res;
  logic    cfg_we;

  // config writes are always taken
  assign cfg_ch.ready = 1'b1;
  assign cfg_we       = cfg_ch.valid;

  // controller
  rsmt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_cmd    (in_ch.cmd),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .dp_cmd    (dp_cmd),
    .dp_sts    (dp_sts)
  );

  // datapath
  rsmt_dpath u_dpath (
    .clk      (clk),
    .rst_n    (rst_n),
    .dp_cmd   (dp_cmd),
    .dp_sts   (dp_sts),
    .in_value (in_ch.value),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_ch.data),
    .res      (res)
  );

  // result payload
  assign out_ch.threshold  = res.threshold;
  assign out_ch.full_res   = res.full_res;
  assign out_ch.kept_value = res.kept_value;
  assign out_ch.kept_count = res.kept_count;
  assign out_ch.empty_res  = res.empty_res;
  assign out_ch.last       = res.last;

endmodule

// ===== tb/running_smallest_m_tracker_test.sv =====
// ----------------------------------------------------------------------------
// running_smallest_m_tracker_test
// Self-checking bench for the smallest-values tracker. Insert and drain
// commands go in under random valid and ready gaps; a local model of the
// sorted kept store predicts every result, and each result that comes out
// is compared field by field with the oldest prediction. The keep limit is
// rewritten between phases while the block is idle.
// ----------------------------------------------------------------------------
module running_smallest_m_tracker_test;
  import rsmt_pkg::*;

  typedef struct {
    logic   cmd;
    value_t value;
  } cmd_item_t;

  logic clk;
  logic rst_n;

  rsmt_in_if  in_ch ();
  rsmt_out_if out_ch ();
  rsmt_cfg_if cfg_ch ();

  running_smallest_m_tracker u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // commands waiting for the driver, results waiting for the block
  cmd_item_t pending_items[$];
  result_t   due_results[$];

  // model of the kept store, ascending, and of the limit register
  value_t             kept_model [MAX_KEEP];
  int                 kept_n    = 0;
  logic [LIMIT_W-1:0] limit_reg = LIMIT_W'(1);

  int err_count = 0;
  bit in_fire   = 1'b0;
  bit out_fire  = 1'b0;
  int in_gap    = 0;
  int out_wait  = 0;
  int in_calm   = 0;
  int out_calm  = 0;

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // run limit
  initial begin
    #2000000;
    $display("simulation failed");
    $finish;
  end

  // limit as the store applies it: zero acts as one, saturates at the size
  function automatic int keep_cap();
    if (limit_reg == '0) return 1;
    if (int'(limit_reg) > MAX_KEEP) return MAX_KEEP;
    return int'(limit_reg);
  endfunction

  // a lowered limit cuts off the largest kept values
  function automatic void set_limit(logic [LIMIT_W-1:0] v);
    limit_reg = v;
    if (kept_n > keep_cap()) kept_n = keep_cap();
  endfunction

  function automatic void add_kept(value_t v);
    int i;
    i = kept_n;
    while (i > 0 && kept_model[i-1] > v) begin
      kept_model[i] = kept_model[i-1];
      i--;
    end
    kept_model[i] = v;
    kept_n++;
  endfunction

  // update the store model and queue the results one command produces
  function automatic void predict_item(cmd_item_t it);
    result_t r;
    int      cap;
    int      prior;
    cap   = keep_cap();
    prior = kept_n;
    r     = '0;
    if (it.cmd == CMD_INSERT) begin
      if (kept_n < cap) begin
        add_kept(it.value);
      end else if (kept_n > 0 && it.value < kept_model[kept_n-1]) begin
        kept_n--;
        add_kept(it.value);
      end
      r.kept_count = COUNT_W'(prior);
      r.last       = 1'b1;
      if (kept_n >= cap) begin
        r.full_res  = 1'b1;
        r.threshold = kept_model[kept_n-1];
      end
      due_results = {due_results, r};
    end else if (kept_n == 0) begin
      r.empty_res = 1'b1;
      r.last      = 1'b1;
      due_results = {due_results, r};
    end else begin
      for (int i = 0; i < prior; i++) begin
        r.kept_value = kept_model[i];
        r.kept_count = COUNT_W'(prior);
        r.last       = (i == prior - 1);
        due_results  = {due_results, r};
      end
      kept_n = 0;
    end
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    err_count++;
    if (err_count <= 100)
      $display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
  endtask

  // idle cycles before the next item, with calm stretches of none
  function automatic int draw_idle(inout int calm_left);
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) calm_left = $urandom_range(8, 30);
    return $urandom_range(0, 11);
  endfunction

  // sample transfers, update the model and check results
  always @(posedge clk) begin
    result_t   want;
    cmd_item_t seen;
    in_fire  = rst_n && in_ch.valid && in_ch.ready;
    out_fire = rst_n && out_ch.valid && out_ch.ready;
    if (rst_n && cfg_ch.valid && cfg_ch.ready) set_limit(cfg_ch.data);
    if (out_fire) begin
      if (due_results.size() == 0) begin
        report("unexpected result, kept_value", 32'(out_ch.kept_value), '0);
      end else begin
        want = due_results.pop_front();
        if (out_ch.threshold !== want.threshold)
          report("threshold", 32'(out_ch.threshold), 32'(want.threshold));
        if (out_ch.full_res !== want.full_res)
          report("full_res", 32'(out_ch.full_res), 32'(want.full_res));
        if (out_ch.kept_value !== want.kept_value)
          report("kept_value", 32'(out_ch.kept_value), 32'(want.kept_value));
        if (out_ch.kept_count !== want.kept_count)
          report("kept_count", 32'(out_ch.kept_count), 32'(want.kept_count));
        if (out_ch.empty_res !== want.empty_res)
          report("empty_res", 32'(out_ch.empty_res), 32'(want.empty_res));
        if (out_ch.last !== want.last)
          report("last", 32'(out_ch.last), 32'(want.last));
      end
    end
    if (in_fire) begin
      seen.cmd   = in_ch.cmd;
      seen.value = in_ch.value;
      predict_item(seen);
    end
  end

  // command driver
  always @(negedge clk) begin
    cmd_item_t it;
    logic      nxt_valid;
    nxt_valid = in_ch.valid;
    if (in_fire) begin
      nxt_valid = 1'b0;
      in_gap    = draw_idle(in_calm);
    end
    if (rst_n && !nxt_valid) begin
      if (in_gap > 0) begin
        in_gap--;
      end else if (pending_items.size() > 0) begin
        it = pending_items.pop_front();
        in_ch.cmd   <= it.cmd;
        in_ch.value <= it.value;
        nxt_valid   = 1'b1;
      end
    end
    in_ch.valid <= nxt_valid;
  end

  // result back-pressure
  always @(negedge clk) begin
    logic nxt_ready;
    nxt_ready = out_ch.ready;
    if (out_fire) begin
      out_wait  = draw_idle(out_calm);
      nxt_ready = (out_wait == 0);
    end else if (!nxt_ready) begin
      if (out_wait > 0) out_wait--;
      nxt_ready = (out_wait == 0);
    end
    out_ch.ready <= nxt_ready;
  end

  task automatic queue_item(logic cmd, value_t v);
    cmd_item_t it;
    it.cmd        = cmd;
    it.value      = v;
    pending_items = {pending_items, it};
  endtask

  // wait until every command is taken and every result is back
  task automatic settle();
    @(posedge clk);
    while (pending_items.size() != 0 || in_ch.valid || due_results.size() != 0)
      @(posedge clk);
    // margin before a limit write
    repeat (2) @(posedge clk);
  endtask

  task automatic write_limit(logic [LIMIT_W-1:0] v);
    settle();
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= v;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // wide values half the time, the rest clustered at either end to force ties
  function automatic value_t pick_value();
    case ($urandom_range(0, 3))
      0:       return value_t'($urandom_range(0, 15));
      1:       return value_t'('1) - value_t'($urandom_range(0, 15));
      default: return value_t'($urandom);
    endcase
  endfunction

  // runs of inserts closed by a drain, with some loose command noise
  task automatic random_phase(logic [LIMIT_W-1:0] lim);
    int cap;
    int budget;
    int made;
    int run;
    write_limit(lim);
    cap    = keep_cap();
    budget = (cap + 2 > 16) ? cap + 2 : 16;
    made   = 0;
    while (made < budget) begin
      if ($urandom_range(0, 3) == 0) begin
        run = $urandom_range(1, 6);
        if (run > budget - made) run = budget - made;
        repeat (run)
          queue_item(($urandom_range(0, 2) == 0) ? CMD_DRAIN : CMD_INSERT, pick_value());
        made += run;
      end else begin
        run = $urandom_range(0, cap + 3);
        if (run > budget - made) run = budget - made;
        repeat (run) queue_item(CMD_INSERT, pick_value());
        made += run;
        // leave the store loaded at times so the next limit may cut it
        if (made < budget || $urandom_range(0, 1) == 1) begin
          queue_item(CMD_DRAIN, pick_value());
          made++;
        end
      end
    end
  endtask

  // stimulus sequence
  initial begin
    in_ch.valid  = 1'b0;
    in_ch.cmd    = CMD_INSERT;
    in_ch.value  = '0;
    out_ch.ready = 1'b1;
    cfg_ch.valid = 1'b0;
    cfg_ch.data  = '0;
    rst_n        = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // reset limit of one: empty drain, extremes, value equal to the kept one
    queue_item(CMD_DRAIN, '1);
    queue_item(CMD_INSERT, '0);
    queue_item(CMD_INSERT, '1);
    queue_item(CMD_INSERT, '0);
    queue_item(CMD_DRAIN, '0);

    // zero limit acts as one
    write_limit(0);
    queue_item(CMD_INSERT, '1);
    queue_item(CMD_INSERT, 18'h2aaaa);
    queue_item(CMD_DRAIN, '0);

    // replacement when full, equal and larger values dropped
    write_limit(3);
    queue_item(CMD_INSERT, 7);
    queue_item(CMD_INSERT, 3);
    queue_item(CMD_INSERT, 9);
    queue_item(CMD_INSERT, 1);
    queue_item(CMD_INSERT, 7);
    queue_item(CMD_INSERT, '1);

    // lowering the limit below the count drops the largest
    write_limit(2);
    queue_item(CMD_DRAIN, '0);
    queue_item(CMD_DRAIN, '0);

    // limit above the store size saturates
    write_limit(63);
    queue_item(CMD_INSERT, 18'h15555);
    queue_item(CMD_INSERT, 18'h2aaaa);
    queue_item(CMD_INSERT, '0);
    queue_item(CMD_DRAIN, '0);

    random_phase(32);
    random_phase(1);
    random_phase(5);
    random_phase(63);
    random_phase(17);
    random_phase(2);
    random_phase(0);
    random_phase(9);

    settle();
    repeat (8) @(posedge clk);
    if (err_count == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule
